/* src/rftp_pkg.sv */
// Package for the reader frame tag parser: constants, codes, event and config types.
// Used by every module in src; depends on nothing else.
package rftp_pkg;

  // Largest payload a frame may announce; sizes the length and count registers.
  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);

  // Depth of the event queue between the parser and the result stage.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 8;

  // Frame layout.
  localparam logic [7:0] HDR_BYTE0      = 8'hDD;
  localparam logic [7:0] HDR_BYTE1      = 8'h11;
  localparam logic [7:0] HDR_BYTE2      = 8'hEF;
  localparam int unsigned FRAME_OVERHEAD = 8;
  localparam int unsigned STATUS_LEN     = 4;
  localparam int unsigned TAG_LEN        = 11;

  // Terminal status codes.
  localparam logic [7:0] STATUS_A = 8'h58;
  localparam logic [7:0] STATUS_B = 8'h59;
  localparam logic [7:0] STATUS_C = 8'h94;
  localparam logic [7:0] STATUS_D = 8'h95;

  // Register reset values.
  localparam logic [7:0] WANTED_OP_RST   = 8'h01;
  localparam logic [7:0] REJECT_BYTE_RST = 8'hF0;
  localparam logic       REJECT_EN_RST   = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT0 = 4'd0,
    PH_HUNT1 = 4'd1,
    PH_HUNT2 = 4'd2,
    PH_LEN   = 4'd3,
    PH_CHAN  = 4'd4,
    PH_OP    = 4'd5,
    PH_DATA  = 4'd6,
    PH_CK1   = 4'd7,
    PH_CK2   = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_TAG    = 3'd0,
    KIND_STATUS = 3'd1,
    KIND_BADHDR = 3'd2,
    KIND_SHORT  = 3'd3,
    KIND_LONG   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    EV_FRAME  = 2'd0,
    EV_BADHDR = 2'd1,
    EV_SHORT  = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    LEN_OTHER  = 2'd0,
    LEN_STATUS = 2'd1,
    LEN_TAG    = 2'd2
  } len_class_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WANTED_OP   = 2'd0,
    CFG_REJECT_BYTE = 2'd1,
    CFG_REJECT_EN   = 2'd2
  } cfg_idx_e;

  // One classified occurrence from the parser.
  typedef struct packed {
    event_e      ev;
    logic [7:0]  operation;
    len_class_e  len_class;
    logic [7:0]  first_byte;
    logic [63:0] tag;
    logic [7:0]  channel;
  } event_t;

  typedef struct packed {
    logic [7:0] wanted_op;
    logic [7:0] reject_byte;
    logic       reject_en;
  } cfg_t;

  function automatic logic is_terminal_status(input logic [7:0] s);
    return (s == STATUS_A) || (s == STATUS_B) || (s == STATUS_C) || (s == STATUS_D);
  endfunction

endpackage

/* src/rftp_front.sv */
// Front end of the frame parser: walks the frame byte by byte and emits events.
// Depends on rftp_pkg.
module rftp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  output logic                byte_ready_o,
  input  logic [7:0]          byte_i,
  output logic                ev_push_o,
  output rftp_pkg::event_t    ev_o,
  input  logic                q_full_i
);
  import rftp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [7:0]       chan_q, chan_d;
  logic [7:0]       op_q, op_d;
  logic [7:0]       first_q, first_d;
  logic [63:0]      tag_q, tag_d;
  logic             accept;
  logic [LEN_W-1:0] cnt_inc;

  assign byte_ready_o = !q_full_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign cnt_inc      = cnt_q + LEN_W'(1);

  // Next state and frame registers.
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    chan_d  = chan_q;
    op_d    = op_q;
    first_d = first_q;
    tag_d   = tag_q;
    if (accept) begin
      case (phase_q)
        PH_HUNT1: phase_d = (byte_i == HDR_BYTE1) ? PH_HUNT2 : PH_HUNT0;
        PH_HUNT2: phase_d = (byte_i == HDR_BYTE2) ? PH_LEN : PH_HUNT0;
        PH_LEN: begin
          if (byte_i < 8'(FRAME_OVERHEAD) ||
              {1'b0, byte_i} > 9'(MAX_PAYLOAD + FRAME_OVERHEAD)) begin
            phase_d = PH_HUNT0;
          end else begin
            len_d   = LEN_W'(byte_i - 8'(FRAME_OVERHEAD));
            phase_d = PH_CHAN;
          end
        end
        PH_CHAN: begin
          chan_d  = byte_i;
          phase_d = PH_OP;
        end
        PH_OP: begin
          op_d    = byte_i;
          cnt_d   = '0;
          first_d = '0;
          tag_d   = '0;
          phase_d = (len_q == '0) ? PH_CK1 : PH_DATA;
        end
        PH_DATA: begin
          if (cnt_q == '0) begin
            first_d = byte_i;
          end
          tag_d = {tag_q[55:0], byte_i};
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CK1;
          end
        end
        PH_CK1:  phase_d = PH_CK2;
        PH_CK2:  phase_d = PH_HUNT0;
        default: phase_d = (byte_i == HDR_BYTE0) ? PH_HUNT1 : PH_HUNT0;
      endcase
    end
  end

  // Event generation.
  always_comb begin
    ev_push_o     = 1'b0;
    ev_o.ev       = EV_FRAME;
    ev_o.operation = op_q;
    ev_o.first_byte = first_q;
    ev_o.tag      = tag_q;
    ev_o.channel  = chan_q;
    if (len_q == LEN_W'(STATUS_LEN)) begin
      ev_o.len_class = LEN_STATUS;
    end else if (len_q == LEN_W'(TAG_LEN)) begin
      ev_o.len_class = LEN_TAG;
    end else begin
      ev_o.len_class = LEN_OTHER;
    end
    if (accept) begin
      case (phase_q)
        PH_HUNT1: begin
          if (byte_i != HDR_BYTE1) begin
            ev_push_o = 1'b1;
            ev_o.ev   = EV_BADHDR;
          end
        end
        PH_HUNT2: begin
          if (byte_i != HDR_BYTE2) begin
            ev_push_o = 1'b1;
            ev_o.ev   = EV_BADHDR;
          end
        end
        PH_LEN: begin
          if (byte_i < 8'(FRAME_OVERHEAD)) begin
            ev_push_o = 1'b1;
            ev_o.ev   = EV_SHORT;
          end else if ({1'b0, byte_i} > 9'(MAX_PAYLOAD + FRAME_OVERHEAD)) begin
            ev_push_o = 1'b1;
            ev_o.ev   = EV_LONG;
          end
        end
        PH_CK2: begin
          ev_push_o = 1'b1;
          ev_o.ev   = EV_FRAME;
        end
        default: ev_push_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT0;
      len_q   <= '0;
      cnt_q   <= '0;
      chan_q  <= '0;
      op_q    <= '0;
      first_q <= '0;
      tag_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      chan_q  <= chan_d;
      op_q    <= op_d;
      first_q <= first_d;
      tag_q   <= tag_d;
    end
  end

endmodule

/* src/rftp_queue.sv */
// Short event queue between the parser and the result stage.
// Depends on rftp_pkg.
module rftp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rftp_pkg::event_t push_data_i,
  input  logic             pop_i,
  output rftp_pkg::event_t head_o,
  output logic             empty_o,
  output logic             full_o
);
  import rftp_pkg::*;

  event_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* src/rftp_back.sv */
// Result stage: interprets queued events against the configuration and holds
// the result word in an output register. Depends on rftp_pkg.
module rftp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rftp_pkg::cfg_t   cfg_i,
  input  rftp_pkg::event_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rftp_pkg::kind_e  kind_o,
  output logic [63:0]      tag_o,
  output logic [7:0]       status_o,
  output logic [7:0]       chan_o
);
  import rftp_pkg::*;

  logic        valid_q, valid_d;
  kind_e       kind_q, kind_d;
  logic [63:0] tag_q, tag_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  chan_q, chan_d;
  logic        emit;
  logic        slot_free;

  assign slot_free = !valid_q || out_ready_i;
  assign pop_o     = !empty_i && slot_free;

  always_comb begin
    emit     = 1'b0;
    kind_d   = KIND_TAG;
    tag_d    = '0;
    status_d = '0;
    chan_d   = '0;
    case (head_i.ev)
      EV_FRAME: begin
        if (head_i.operation == cfg_i.wanted_op) begin
          case (head_i.len_class)
            LEN_STATUS: begin
              if (is_terminal_status(head_i.first_byte)) begin
                emit     = 1'b1;
                kind_d   = KIND_STATUS;
                status_d = head_i.first_byte;
                chan_d   = head_i.channel;
              end
            end
            LEN_TAG: begin
              if (!(cfg_i.reject_en && head_i.tag[7:0] == cfg_i.reject_byte)) begin
                emit   = 1'b1;
                kind_d = KIND_TAG;
                tag_d  = head_i.tag;
                chan_d = head_i.channel;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      EV_BADHDR: begin
        emit   = 1'b1;
        kind_d = KIND_BADHDR;
      end
      EV_SHORT: begin
        emit   = 1'b1;
        kind_d = KIND_SHORT;
      end
      EV_LONG: begin
        emit   = 1'b1;
        kind_d = KIND_LONG;
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (pop_o) begin
      valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      kind_q   <= kind_d;
      tag_q    <= tag_d;
      status_q <= status_d;
      chan_q   <= chan_d;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign tag_o       = tag_q;
  assign status_o    = status_q;
  assign chan_o      = chan_q;

endmodule

/* src/reader_frame_tag_parser_top.sv */
// Top level of the reader frame tag parser: configuration registers, parser,
// event queue and result stage. Depends on rftp_pkg, rftp_front, rftp_queue, rftp_back.
//
// The block takes one received byte per word on the input stream and parses
// reader reply frames: header dd 11 ef, a length byte, a channel byte, an
// operation byte, length minus 8 payload bytes, and two checksum bytes that
// are skipped. Frames carrying the wanted operation yield a status result
// (4-byte payload starting with a terminal status code) or a tag result
// (11-byte payload; the tag is payload bytes 3 to 10, dropped when its last
// byte matches the reject byte and rejection is enabled). A bad second or
// third header byte, a length below 8 or a payload above the maximum yields
// an error result and the parser returns to hunting for the header. The
// input accepts one byte every cycle while the queue has room. An event is
// written into the queue, and its result word from there into the output
// register; a stalled output holds it back for as long as the stall lasts.
// The parser hands events to a four-entry queue; the input stalls only when
// that queue is full, which happens only while the output holds results back.
// Configuration is taken through a plain write port and must be written
// while no byte is in flight, that is with the queue and the output empty.
module reader_frame_tag_parser_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] rx_byte
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [79:0]                    m_axis_tdata_o,  // [63:0] tag_id,
                                                          // [71:64] status_code,
                                                          // [79:72] frame_channel
  output logic [2:0]                     m_axis_tuser_o,  // [2:0] result_kind
  input  logic                           cfg_we_i,
  input  logic [rftp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rftp_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import rftp_pkg::*;

  cfg_t        cfg_q, cfg_d;
  event_t      push_ev;
  event_t      head_ev;
  logic        push;
  logic        pop;
  logic        q_empty;
  logic        q_full;
  kind_e       res_kind;
  logic [63:0] res_tag;
  logic [7:0]  res_status;
  logic [7:0]  res_chan;

  // Configuration registers; an index beyond the list writes nothing.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WANTED_OP:   cfg_d.wanted_op   = cfg_wdata_i[7:0];
        CFG_REJECT_BYTE: cfg_d.reject_byte = cfg_wdata_i[7:0];
        CFG_REJECT_EN:   cfg_d.reject_en   = cfg_wdata_i[0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wanted_op   <= WANTED_OP_RST;
      cfg_q.reject_byte <= REJECT_BYTE_RST;
      cfg_q.reject_en   <= REJECT_EN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rftp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .ev_push_o    (push),
    .ev_o         (push_ev),
    .q_full_i     (q_full)
  );

  rftp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_ev),
    .pop_i       (pop),
    .head_o      (head_ev),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  rftp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head_ev),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .kind_o      (res_kind),
    .tag_o       (res_tag),
    .status_o    (res_status),
    .chan_o      (res_chan)
  );

  assign m_axis_tdata_o = {res_chan, res_status, res_tag};
  assign m_axis_tuser_o = res_kind;

  // The parser never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("event pushed into full queue");

  // The input side stalls only because the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !s_axis_tready_o |-> q_full)
    else $error("input stalled while queue has room");

  // Error results carry no tag, status or channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res_kind == KIND_BADHDR || res_kind == KIND_SHORT ||
                         res_kind == KIND_LONG))
    |-> (res_tag == '0 && res_status == '0 && res_chan == '0))
    else $error("error result carries payload");

  // A status result always holds one of the terminal status codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_kind == KIND_STATUS) |-> is_terminal_status(res_status))
    else $error("status result with non-terminal code");

endmodule
